// File: src/lss_pkg.sv
// lss_pkg: shared constants for the lifo stack with search
// operation and status codes, field widths, default depth
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lss_pkg;

    // field widths
    localparam int OP_W  = 2;
    localparam int VAL_W = 32;
    localparam int ST_W  = 3;
    localparam int POS_W = 8;
    localparam int ENT_W = 9;

    // default number of stack entries
    localparam int DEPTH_DEF = 256;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OP_W-1:0] OP_POP    = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    // status codes
    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_UNDERFLOW = 3'd1;
    localparam logic [ST_W-1:0] ST_OVERFLOW  = 3'd2;
    localparam logic [ST_W-1:0] ST_FOUND     = 3'd3;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd4;

endpackage

`default_nettype wire

// File: src/lss_ram.sv
// lss_ram: stack word storage, one write port and one read port
// read data is registered; uses lss_pkg
`timescale 1ns / 1ps
`default_nettype none

module lss_ram #(
    parameter int DEPTH = lss_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [AW-1:0]              i_waddr,
    input  wire logic [lss_pkg::VAL_W-1:0]  i_wdata,
    input  wire logic [AW-1:0]              i_raddr,
    output logic      [lss_pkg::VAL_W-1:0]  o_rdata
);
    import lss_pkg::*;

    logic [VAL_W-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: src/lss_ctrl.sv
// lss_ctrl: request sequencer, fill count and search walk for the stack
// drives the write and read ports of lss_ram and registers each result; uses lss_pkg
`timescale 1ns / 1ps
`default_nettype none

module lss_ctrl #(
    parameter int DEPTH = lss_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    input  wire logic [lss_pkg::OP_W-1:0]   i_operation,
    input  wire logic [lss_pkg::VAL_W-1:0]  i_value,
    output logic                            busy,
    output logic                            o_done,
    output logic      [lss_pkg::ST_W-1:0]   o_status,
    output logic      [lss_pkg::POS_W-1:0]  o_position,
    output logic      [lss_pkg::ENT_W-1:0]  o_entries,
    output logic                            o_mem_we,
    output logic      [AW-1:0]              o_mem_waddr,
    output logic      [lss_pkg::VAL_W-1:0]  o_mem_wdata,
    output logic      [AW-1:0]              o_mem_raddr,
    input  wire logic [lss_pkg::VAL_W-1:0]  i_mem_rdata
);
    import lss_pkg::*;

    localparam logic [CW-1:0] FULL_C = CW'(DEPTH);

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_fill, n_fill;
    logic [AW-1:0]       r_k, n_k;
    logic [VAL_W-1:0]    r_target, n_target;
    logic                r_done, n_done;
    logic [ST_W-1:0]     r_status, n_status;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [ENT_W-1:0]    r_ent, n_ent;

    logic [CW-1:0]       fill_m1;
    logic [CW-1:0]       walk_addr;
    logic [AW+POS_W-1:0] k_ext;
    logic [CW+ENT_W-1:0] fill_ext;

    // address arithmetic for the top entry and the next walk step
    assign fill_m1   = r_fill - CW'(1);
    assign walk_addr = r_fill - CW'(2) - CW'(r_k);
    assign k_ext     = {{POS_W{1'b0}}, r_k};
    assign fill_ext  = {{ENT_W{1'b0}}, n_fill};
    assign n_ent     = fill_ext[ENT_W-1:0];

    // next-state and result logic
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_k         = r_k;
        n_target    = r_target;
        n_done      = 1'b0;
        n_status    = r_status;
        n_pos       = r_pos;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_fill[AW-1:0];
        o_mem_wdata = i_value;
        o_mem_raddr = fill_m1[AW-1:0];
        case (r_state)
            S_IDLE: begin
                // first read of a search targets the top entry
                o_mem_raddr = fill_m1[AW-1:0];
                if (start) begin
                    n_pos = '0;
                    case (i_operation)
                        OP_PUSH: begin
                            n_done = 1'b1;
                            if (r_fill == FULL_C) begin
                                n_status = ST_OVERFLOW;
                            end else begin
                                o_mem_we = 1'b1;
                                n_fill   = r_fill + CW'(1);
                                n_status = ST_OK;
                            end
                        end
                        OP_POP: begin
                            n_done = 1'b1;
                            if (r_fill == '0) begin
                                n_status = ST_UNDERFLOW;
                            end else begin
                                n_fill   = fill_m1;
                                n_status = ST_OK;
                            end
                        end
                        OP_SEARCH: begin
                            if (r_fill == '0) begin
                                n_done   = 1'b1;
                                n_status = ST_NOT_FOUND;
                            end else begin
                                n_state  = S_SEARCH;
                                n_k      = '0;
                                n_target = i_value;
                            end
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                // compare the word at position r_k, prefetch the one below
                o_mem_raddr = walk_addr[AW-1:0];
                if (i_mem_rdata == r_target) begin
                    n_done   = 1'b1;
                    n_status = ST_FOUND;
                    n_pos    = k_ext[POS_W-1:0];
                    n_state  = S_IDLE;
                end else if (CW'(r_k) == fill_m1) begin
                    n_done   = 1'b1;
                    n_status = ST_NOT_FOUND;
                    n_pos    = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_k = r_k + AW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_done  <= n_done;
        end
        r_k      <= n_k;
        r_target <= n_target;
        r_status <= n_status;
        r_pos    <= n_pos;
        r_ent    <= n_ent;
    end

    assign busy       = (r_state == S_SEARCH);
    assign o_done     = r_done;
    assign o_status   = r_status;
    assign o_position = r_pos;
    assign o_entries  = r_ent;

endmodule

`default_nettype wire

// File: src/lifo_stack_with_search_core.sv
// lifo_stack_with_search_core: top level of the searchable lifo stack
// instantiates lss_ctrl and lss_ram; uses lss_pkg
//
// usage:
//   request channel: start, i_operation, i_value; a request is taken at a
//   rising edge with start high and busy low. operations: push, pop, search.
//   result channel: o_done strobes for one cycle with o_status, o_position
//   and o_entries; the receiver cannot stall, so each result must be
//   captured in its strobe cycle.
// latency and throughput:
//   push, pop and unused codes: result in the cycle after the request;
//   busy stays low, so one of these can be taken every cycle.
//   search: one stored word is compared per cycle, top first, paced by the
//   single read port of the word memory with its registered read data.
//   a match ends the walk at the matching position nearest the top; without
//   a match every stored entry is compared. busy is high meanwhile.
//   a search of an empty stack answers in the next cycle.
// reset:
//   synchronous active-low reset empties the stack; no memory clearing
//   pass is needed, since only entries below the fill count are read.
`timescale 1ns / 1ps
`default_nettype none

module lifo_stack_with_search_core #(
    parameter int DEPTH = lss_pkg::DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    input  wire logic        [lss_pkg::OP_W-1:0]   i_operation,
    input  wire logic signed [lss_pkg::VAL_W-1:0]  i_value,
    output logic                                   busy,
    output logic                                   o_done,
    output logic             [lss_pkg::ST_W-1:0]   o_status,
    output logic             [lss_pkg::POS_W-1:0]  o_position,
    output logic             [lss_pkg::ENT_W-1:0]  o_entries
);
    import lss_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [VAL_W-1:0] mem_rdata;
    logic [VAL_W-1:0] value_bits;

    assign value_bits = i_value;

    // sequencer and result registers
    lss_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_operation (i_operation),
        .i_value     (value_bits),
        .busy        (busy),
        .o_done      (o_done),
        .o_status    (o_status),
        .o_position  (o_position),
        .o_entries   (o_entries),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    // stack word memory
    lss_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// File: src/lss_checker.sv
// lss_checker: port-level checks for lifo_stack_with_search_core
// bound to the top level below; uses lss_pkg
`timescale 1ns / 1ps
`default_nettype none

module lss_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       start,
    input wire logic [lss_pkg::OP_W-1:0]   i_operation,
    input wire logic                       busy,
    input wire logic                       o_done,
    input wire logic [lss_pkg::ST_W-1:0]   o_status,
    input wire logic [lss_pkg::POS_W-1:0]  o_position,
    input wire logic [lss_pkg::ENT_W-1:0]  o_entries
);
    import lss_pkg::*;

    // a non-search request answers in the next cycle
    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation != OP_SEARCH) |=> o_done)
        else $error("no result one cycle after a push or pop request");

    // a result is never shown while a search walk is still running
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // position is zero unless a match was found
    a_position_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_FOUND) |-> (o_position == '0))
        else $error("nonzero position without a match");

    // underflow only happens on an empty stack
    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_UNDERFLOW) |-> (o_entries == '0))
        else $error("underflow reported with entries held");

endmodule

bind lifo_stack_with_search_core lss_checker u_lss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .i_operation (i_operation),
    .busy        (busy),
    .o_done      (o_done),
    .o_status    (o_status),
    .o_position  (o_position),
    .o_entries   (o_entries)
);

`default_nettype wire

// File: test/lifo_stack_with_search_core_tb.sv
// lifo_stack_with_search_core_tb: self-checking bench for the searchable lifo stack
// drives push, pop, search and unused-code requests in paced bursts, predicts every result
// and checks each strobed result; depends on lss_pkg and lifo_stack_with_search_core
`timescale 1ns / 1ps

module lifo_stack_with_search_core_tb;
    import lss_pkg::*;

    localparam int DEPTH = DEPTH_DEF;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam longint TIMEOUT_NS = 64'd15_000_000;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [POS_W-1:0] position;
        logic [ENT_W-1:0] entries;
    } t_stack_result;

    // dut connections; the driven inputs are known from time zero
    logic                    i_clk     = 1'b0;
    logic                    i_rst_n   = 1'b0;
    logic                    start     = 1'b0;
    logic [OP_W-1:0]         req_op    = OP_PUSH;
    logic signed [VAL_W-1:0] req_value = '0;
    logic                    busy;
    logic                    o_done;
    logic [ST_W-1:0]         o_status;
    logic [POS_W-1:0]        o_position;
    logic [ENT_W-1:0]        o_entries;

    // predicted stack contents and expected results
    logic [VAL_W-1:0] model_words [DEPTH];
    int               model_fill = 0;
    t_stack_result    pending_results [$];
    int               error_count = 0;
    int               burst_left  = 0;

    lifo_stack_with_search_core #(
        .DEPTH(DEPTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_operation(req_op),
        .i_value    (req_value),
        .busy       (busy),
        .o_done     (o_done),
        .o_status   (o_status),
        .o_position (o_position),
        .o_entries  (o_entries)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // hard stop if the run hangs
    initial begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    // apply one request to the predicted stack and return its result
    function automatic t_stack_result predict_stack_op(logic [OP_W-1:0] op,
                                                       logic [VAL_W-1:0] word);
        t_stack_result r;
        int k;
        r.status   = ST_OK;
        r.position = '0;
        case (op)
            OP_PUSH: begin
                if (model_fill >= DEPTH) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    model_words[model_fill] = word;
                    model_fill++;
                end
            end
            OP_POP: begin
                if (model_fill == 0) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    model_fill--;
                end
            end
            OP_SEARCH: begin
                r.status = ST_NOT_FOUND;
                for (k = 0; k < model_fill; k++) begin
                    if (model_words[model_fill - 1 - k] == word) begin
                        r.status   = ST_FOUND;
                        r.position = POS_W'(k);
                        break;
                    end
                end
            end
            default: begin
                // unused code leaves the stack alone
            end
        endcase
        r.entries = ENT_W'(model_fill);
        return r;
    endfunction

    // predict on every accepted request
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && start === 1'b1 && busy === 1'b0) begin
            pending_results.push_back(predict_stack_op(req_op, req_value));
        end
    end

    // compare every strobed result with the oldest expectation
    always @(posedge i_clk) begin
        t_stack_result want;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("result with no request waiting: status %0d position %0d entries %0d",
                       o_status, o_position, o_entries);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, o_status);
                    error_count++;
                end
                if (o_position !== want.position) begin
                    $error("position mismatch: expected %0d, actual %0d",
                           want.position, o_position);
                    error_count++;
                end
                if (o_entries !== want.entries) begin
                    $error("entries mismatch: expected %0d, actual %0d",
                           want.entries, o_entries);
                    error_count++;
                end
            end
        end
    end

    // hold a request until the block takes it
    task automatic send_request(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] word);
        start     <= 1'b1;
        req_op    <= op;
        req_value <= word;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
    endtask

    // drop start for a number of cycles
    task automatic pause_requests(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // send one request, inserting a random gap at the end of each burst
    task automatic issue_request(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] word);
        send_request(op, word);
        if (burst_left == 0) begin
            pause_requests($urandom_range(1, 6));
            burst_left = $urandom_range(0, 40);
        end else begin
            burst_left--;
        end
    endtask

    // stop requesting and wait until every expected result has come back
    task automatic wait_results_drained();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // words drawn often from a small set so that searches hit and repeat
    function automatic logic [VAL_W-1:0] pick_word();
        logic [VAL_W-1:0] w;
        w = $urandom;
        if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 7))
                0: w = 32'h0000_0000;
                1: w = 32'h0000_0001;
                2: w = 32'hFFFF_FFFF;
                3: w = 32'h8000_0000;
                4: w = 32'h7FFF_FFFF;
                5: w = 32'd42;
                6: w = 32'hDEAD_BEEF;
                default: w = 32'd7;
            endcase
        end
        return w;
    endfunction

    // pop, search and unused code on an empty stack
    task automatic test_empty_stack();
        issue_request(OP_POP, 32'h0000_0000);
        issue_request(OP_SEARCH, 32'h0000_0000);
        issue_request(OP_UNUSED, 32'hFFFF_FFFF);
    endtask

    // extreme words pushed, found at every depth, then popped to underflow
    task automatic test_push_extremes();
        issue_request(OP_PUSH, 32'h8000_0000);
        issue_request(OP_PUSH, 32'h7FFF_FFFF);
        issue_request(OP_PUSH, 32'h0000_0000);
        issue_request(OP_PUSH, 32'hFFFF_FFFF);
        issue_request(OP_SEARCH, 32'hFFFF_FFFF);
        issue_request(OP_SEARCH, 32'h0000_0000);
        issue_request(OP_SEARCH, 32'h7FFF_FFFF);
        issue_request(OP_SEARCH, 32'h8000_0000);
        issue_request(OP_SEARCH, 32'd12345);
        issue_request(OP_UNUSED, 32'h5555_AAAA);
        repeat (4) issue_request(OP_POP, $urandom);
        issue_request(OP_POP, 32'hFFFF_FFFF);
    endtask

    // several matches: the one nearest the top wins
    task automatic test_duplicate_matches();
        issue_request(OP_PUSH, 32'd5);
        issue_request(OP_PUSH, 32'd9);
        issue_request(OP_PUSH, 32'd5);
        issue_request(OP_PUSH, 32'd5);
        issue_request(OP_SEARCH, 32'd5);
        issue_request(OP_POP, 32'd0);
        issue_request(OP_POP, 32'd0);
        issue_request(OP_SEARCH, 32'd5);
        issue_request(OP_SEARCH, 32'd9);
        issue_request(OP_POP, 32'd0);
        issue_request(OP_POP, 32'd0);
        issue_request(OP_SEARCH, 32'd5);
    endtask

    // fill to depth, overflow, deepest match, then drain past empty
    task automatic test_full_stack();
        logic [VAL_W-1:0] marker;
        logic [VAL_W-1:0] w;
        int i;
        int held;
        marker = 32'h5A5A_1234;
        wait_results_drained();
        held = model_fill;
        for (i = 0; i < held; i++) issue_request(OP_POP, $urandom);
        issue_request(OP_PUSH, marker);
        for (i = 1; i < DEPTH; i++) begin
            w = $urandom;
            if (w == marker) w = ~w;
            issue_request(OP_PUSH, w);
        end
        issue_request(OP_PUSH, 32'h7FFF_FFFF);
        issue_request(OP_PUSH, 32'h8000_0000);
        issue_request(OP_SEARCH, marker);
        issue_request(OP_SEARCH, ~marker);
        issue_request(OP_UNUSED, $urandom);
        issue_request(OP_POP, $urandom);
        issue_request(OP_PUSH, marker);
        issue_request(OP_SEARCH, marker);
        for (i = 0; i < DEPTH; i++) issue_request(OP_POP, $urandom);
        issue_request(OP_POP, $urandom);
        issue_request(OP_SEARCH, marker);
    endtask

    // random mix, alternating between filling and draining phases
    task automatic test_random_mix(input int count);
        int i;
        int roll;
        bit growing;
        growing = 1'b0;
        for (i = 0; i < count; i++) begin
            if (i % 150 == 0) growing = !growing;
            roll = $urandom_range(0, 99);
            if (roll < (growing ? 55 : 20)) begin
                issue_request(OP_PUSH, pick_word());
            end else if (roll < (growing ? 75 : 60)) begin
                issue_request(OP_POP, $urandom);
            end else if (roll < 96) begin
                issue_request(OP_SEARCH, ($urandom_range(0, 3) != 0) ? pick_word() : $urandom);
            end else begin
                issue_request(OP_UNUSED, $urandom);
            end
        end
    endtask

    // reset, run the tests, drain and report
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        burst_left = $urandom_range(0, 40);
        test_empty_stack();
        test_push_extremes();
        test_duplicate_matches();
        test_full_stack();
        test_random_mix(600);
        pause_requests(1);
        wait_results_drained();
        repeat (DEPTH + 8) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            if (pending_results.size() != 0) begin
                $error("%0d expected results never arrived", pending_results.size());
            end
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
